// ===== rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg - shared constants for the tagged branch predictor
// Table geometry, prediction mode codes and history state codes.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int IDX_LSB       = 3;
    localparam int ADDR_W        = 32;
    localparam int HIST_W        = 2;
    localparam int MODE_W        = 2;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [HIST_W-1:0] t_hist;

    localparam t_mode MODE_NOT_TAKEN = 2'd0;
    localparam t_mode MODE_ONE_BIT   = 2'd1;
    localparam t_mode MODE_TWO_BIT   = 2'd2;

    localparam t_hist HIST_STRONG_NT = 2'd0;
    localparam t_hist HIST_WEAK_NT   = 2'd1;
    localparam t_hist HIST_WEAK_T    = 2'd2;
    localparam t_hist HIST_STRONG_T  = 2'd3;

endpackage

// ===== rtl/tbp_if.sv =====
// ----------------------------------------------------------------------------
// tbp_if - valid/ready channels of the tagged branch predictor
// One interface for resolved branch beats, one for prediction result beats.
// ----------------------------------------------------------------------------
interface tbp_in_if;
    logic                       valid;
    logic                       ready;
    logic [tbp_pkg::ADDR_W-1:0] target_address;
    logic [tbp_pkg::ADDR_W-1:0] next_pc;

    modport source (output valid, output target_address, output next_pc, input ready);
    modport sink   (input valid, input target_address, input next_pc, output ready);
endinterface

interface tbp_out_if;
    logic valid;
    logic ready;
    logic taken;
    logic mispredict;

    modport source (output valid, output taken, output mispredict, input ready);
    modport sink   (input valid, input taken, input mispredict, output ready);
endinterface

// ===== rtl/tagged_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tagged_branch_predictor - tagged bimodal predictor with resolve feedback
// Scores each resolved branch against a tagged history table and updates it.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one resolved branch per beat (target_address, next_pc). The
//   branch counts as taken when both are equal. o_out returns one beat per
//   input beat: taken and mispredict, in input order.
//   i_cfg_we / i_cfg_wdata write prediction_mode (0 never taken, 1 one-bit,
//   2 two-bit, 3 acts as 0). Write it only while the block is idle.
// Timing:
//   The table read is issued at the accepting edge; in the next cycle the
//   entry is updated and the output register loads. A new beat is accepted
//   only once the previous one has finished its update, set by the
//   read-then-write of the single table port.
// Reset:
//   Synchronous, active low. Mode returns to 0 and per-entry valid flops
//   clear, so every entry reads as tag zero, history zero right away.
// Stall:
//   While a result sits unread in the output register, a new beat is taken
//   only in the cycle that register drains; otherwise i_in.ready stays low.
// ----------------------------------------------------------------------------
module tagged_branch_predictor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tbp_pkg::MODE_W-1:0] i_cfg_wdata,
    tbp_in_if.sink                    i_in,
    tbp_out_if.source                 o_out
);

    localparam int ENTRY_W = tbp_pkg::ADDR_W + tbp_pkg::HIST_W;

    typedef enum logic {ST_IDLE, ST_UPDATE} t_state;

    // table entry: {tag, history}
    logic [ENTRY_W-1:0]             mem [tbp_pkg::TABLE_ENTRIES];

    t_state                         r_state;
    tbp_pkg::t_mode                 r_mode;
    logic [tbp_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic [ENTRY_W-1:0]             r_rd_data;
    logic                           r_rd_valid;
    logic [tbp_pkg::ADDR_W-1:0]     r_addr;
    logic [tbp_pkg::IDX_W-1:0]      r_idx;
    logic                           r_taken;
    logic                           r_out_valid;
    logic                           r_out_taken;
    logic                           r_out_miss;

    logic                           accept;
    logic [tbp_pkg::IDX_W-1:0]      in_idx;
    logic [tbp_pkg::ADDR_W-1:0]     entry_tag;
    tbp_pkg::t_hist                 entry_hist;
    logic                           hit;
    logic                           wr_en;
    tbp_pkg::t_hist                 n_hist;
    logic                           n_miss;

    // take a beat only when idle and the output register is free by next edge
    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign in_idx     = i_in.target_address[tbp_pkg::IDX_LSB +: tbp_pkg::IDX_W];

    assign o_out.valid      = r_out_valid;
    assign o_out.taken      = r_out_taken;
    assign o_out.mispredict = r_out_miss;

    // entries never written since reset read as all zero
    assign entry_tag  = r_rd_valid ? r_rd_data[ENTRY_W-1:tbp_pkg::HIST_W] : '0;
    assign entry_hist = r_rd_valid ? r_rd_data[tbp_pkg::HIST_W-1:0] : tbp_pkg::HIST_STRONG_NT;
    assign hit        = (entry_tag == r_addr);

    // prediction and history update
    always_comb begin
        wr_en  = 1'b0;
        n_hist = entry_hist;
        n_miss = r_taken;
        if (r_mode == tbp_pkg::MODE_ONE_BIT || r_mode == tbp_pkg::MODE_TWO_BIT) begin
            wr_en = 1'b1;
            if (!hit) begin
                // replace entry; a fresh entry predicts not taken
                n_hist = !r_taken ? tbp_pkg::HIST_STRONG_NT :
                         (r_mode == tbp_pkg::MODE_ONE_BIT) ? tbp_pkg::HIST_WEAK_NT :
                                                             tbp_pkg::HIST_STRONG_T;
                n_miss = r_taken;
            end else if (r_mode == tbp_pkg::MODE_ONE_BIT) begin
                n_hist = {1'b0, r_taken};
                n_miss = (entry_hist != {1'b0, r_taken});
            end else begin
                case (entry_hist)
                    tbp_pkg::HIST_STRONG_NT: begin
                        n_hist = r_taken ? tbp_pkg::HIST_WEAK_NT : tbp_pkg::HIST_STRONG_NT;
                        n_miss = r_taken;
                    end
                    tbp_pkg::HIST_WEAK_NT: begin
                        n_hist = r_taken ? tbp_pkg::HIST_STRONG_T : tbp_pkg::HIST_STRONG_NT;
                        n_miss = r_taken;
                    end
                    tbp_pkg::HIST_WEAK_T: begin
                        n_hist = r_taken ? tbp_pkg::HIST_STRONG_T : tbp_pkg::HIST_STRONG_NT;
                        n_miss = !r_taken;
                    end
                    default: begin
                        n_hist = r_taken ? tbp_pkg::HIST_STRONG_T : tbp_pkg::HIST_WEAK_T;
                        n_miss = !r_taken;
                    end
                endcase
            end
        end
    end

    // table memory: read on accept, write back in the update cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= mem[in_idx];
        end
        if (r_state == ST_UPDATE && wr_en) begin
            mem[r_idx] <= {r_addr, n_hist};
        end
    end

    // control, valid flops and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= tbp_pkg::MODE_NOT_TAKEN;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    // drop the result once the receiver takes it
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_state    <= ST_UPDATE;
                        r_rd_valid <= r_valid[in_idx];
                    end
                end
                ST_UPDATE: begin
                    // output register is empty here: the accept drained it
                    r_state     <= ST_IDLE;
                    r_out_valid <= 1'b1;
                    r_out_taken <= r_taken;
                    r_out_miss  <= n_miss;
                    if (wr_en) begin
                        r_valid[r_idx] <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers: hold the beat under work
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr  <= i_in.target_address;
            r_idx   <= in_idx;
            r_taken <= (i_in.target_address == i_in.next_pc);
        end
    end

endmodule

// ===== tb/branch_outcome_checker.sv =====
// ----------------------------------------------------------------------------
// branch_outcome_checker - prediction scoreboard for the tagged predictor
// Watches the branch and result channels and keeps its own tagged history
// table. Each accepted branch beat yields one expected outcome, and each
// result beat is compared with the oldest one.
// ----------------------------------------------------------------------------
module branch_outcome_checker
    import tbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_wdata,
    tbp_in_if                 i_br,
    tbp_out_if                i_res,
    output int                o_mismatches,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic taken;
        logic mispredict;
    } t_outcome;

    logic [ADDR_W-1:0] tag_mem  [TABLE_ENTRIES];
    t_hist             hist_mem [TABLE_ENTRIES];
    t_mode             mode_q;
    t_outcome          outcome_q [$];
    int                mismatch_cnt = 0;

    assign o_mismatches = mismatch_cnt;

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("[%0t] %s: got %b, expected %b", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // Score one resolved branch and update the table as the active mode does.
    function automatic t_outcome resolve_branch(logic [ADDR_W-1:0] addr,
                                                logic [ADDR_W-1:0] npc);
        logic [IDX_W-1:0] idx;
        t_hist            st;
        t_outcome         res;
        idx            = addr[IDX_LSB +: IDX_W];
        res.taken      = (addr == npc);
        res.mispredict = res.taken;
        if (mode_q == MODE_ONE_BIT || mode_q == MODE_TWO_BIT) begin
            if (tag_mem[idx] != addr) begin
                // replaced entry predicts not-taken
                tag_mem[idx]  = addr;
                hist_mem[idx] = !res.taken ? HIST_STRONG_NT :
                                (mode_q == MODE_ONE_BIT) ? HIST_WEAK_NT : HIST_STRONG_T;
            end else if (mode_q == MODE_ONE_BIT) begin
                st             = res.taken ? HIST_WEAK_NT : HIST_STRONG_NT;
                res.mispredict = (hist_mem[idx] != st);
                hist_mem[idx]  = st;
            end else begin
                st = hist_mem[idx];
                case (st)
                    HIST_STRONG_NT: begin
                        res.mispredict = res.taken;
                        if (res.taken) st = HIST_WEAK_NT;
                    end
                    HIST_WEAK_NT: begin
                        res.mispredict = res.taken;
                        st = res.taken ? HIST_STRONG_T : HIST_STRONG_NT;
                    end
                    HIST_WEAK_T: begin
                        res.mispredict = !res.taken;
                        st = res.taken ? HIST_STRONG_T : HIST_STRONG_NT;
                    end
                    default: begin
                        res.mispredict = !res.taken;
                        st = res.taken ? HIST_STRONG_T : HIST_WEAK_T;
                    end
                endcase
                hist_mem[idx] = st;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tag_mem[i]  = '0;
                hist_mem[i] = HIST_STRONG_NT;
            end
            mode_q = MODE_NOT_TAKEN;
            outcome_q.delete();
        end else begin
            if (i_br.valid && i_br.ready)
                outcome_q.push_back(resolve_branch(i_br.target_address, i_br.next_pc));
            if (i_res.valid && i_res.ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected result beat", 1'b1, 1'b0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_res.taken !== want.taken)
                        report_mismatch("taken", i_res.taken, want.taken);
                    if (i_res.mispredict !== want.mispredict)
                        report_mismatch("mispredict", i_res.mispredict, want.mispredict);
                end
            end
            if (i_cfg_we)
                mode_q = i_cfg_wdata;
        end
        o_pending <= outcome_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench for the tagged branch predictor
// Drives resolved branches through every prediction mode, first a directed
// walk over the history transitions, then random branches drawn from small
// address pools so that entries hit, conflict and saturate. Both channel
// sides idle at random in phases; the checker scores every result beat.
// ----------------------------------------------------------------------------
module tb_top;
    import tbp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Mode value 3 is unused by the block and must act as never-taken.
    localparam t_mode MODE_SPARE  = 2'd3;
    localparam int    NUM_PHASES  = 8;
    localparam int    PHASE_BEATS = 92;
    localparam int    POOL_SIZE   = 24;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MODE_W-1:0] i_cfg_wdata;
    int                mismatches;
    int                pending;

    // Idle percentages applied by the sender and the receiver.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    logic [ADDR_W-1:0] addr_pool  [POOL_SIZE];
    int                taken_bias [POOL_SIZE];

    tbp_in_if  br_ch ();
    tbp_out_if res_ch ();

    tagged_branch_predictor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (br_ch),
        .o_out       (res_ch)
    );

    branch_outcome_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_br         (br_ch),
        .i_res        (res_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: roll a stall each cycle, change only on the falling edge.
    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop in case the handshake locks up.
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Present one branch beat, idling first as the sender's rate says, and
    // hold it until the block takes it. Valid stays high after the accepting
    // edge; the next call or drain_branches decides what it does next.
    task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] npc);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            br_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        br_ch.valid          <= 1'b1;
        br_ch.target_address <= addr;
        br_ch.next_pc        <= npc;
        do @(posedge i_clk); while (!br_ch.ready);
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic drain_branches();
        @(negedge i_clk);
        br_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Write the mode only once the block has gone idle.
    task automatic set_mode(input t_mode m);
        drain_branches();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_mode mode_for_phase(input int p);
        case (p)
            0, 3, 5, 7: return MODE_TWO_BIT;
            1, 6:       return MODE_ONE_BIT;
            2:          return MODE_NOT_TAKEN;
            default:    return MODE_SPARE;
        endcase
    endfunction

    // Fresh address pool per phase; each address gets its own taken bias so
    // that some entries saturate and others flip back and forth.
    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i]  = $urandom;
            taken_bias[i] = $urandom_range(100);
        end
        // alias a few entries onto the same index with another tag
        for (int i = 0; i < 4; i++)
            addr_pool[POOL_SIZE-1-i] = addr_pool[i] ^ ($urandom | 32'h0000_0100) & 32'hFFFF_FF07;
        if ($urandom_range(1))
            addr_pool[4] = '0;
    endtask

    task automatic send_random_branch();
        int                k;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] npc;
        k = $urandom_range(POOL_SIZE-1);
        addr = ($urandom_range(9) == 0) ? $urandom : addr_pool[k];
        if ($urandom_range(99) < taken_bias[k])
            npc = addr;
        else if ($urandom_range(1))
            npc = $urandom;
        else
            npc = addr ^ (32'h1 << $urandom_range(31));
        send_branch(addr, npc);
    endtask

    initial begin
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] c;

        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = MODE_NOT_TAKEN;
        br_ch.valid          = 1'b0;
        br_ch.target_address = '0;
        br_ch.next_pc        = '0;
        res_ch.ready         = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // One-bit mode: address zero hits the cleared entries right after
        // reset; then the all-ones address misses and settles.
        set_mode(MODE_ONE_BIT);
        send_branch(32'h0000_0000, 32'h0000_0000);
        send_branch(32'h0000_0000, 32'h0000_0004);
        send_branch(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_branch(32'hFFFF_FFFF, 32'h0000_0000);
        send_branch(32'hFFFF_FFFF, 32'h0000_0000);

        // Two-bit mode: walk every state along both directions on one entry.
        a = 32'h8000_0058;
        b = a ^ 32'h0000_0100;      // same index, other tag
        c = 32'h0000_00F8;
        set_mode(MODE_TWO_BIT);
        send_branch(a, a);          // miss, taken: enter strong taken
        send_branch(a, '0);         // strong taken -> weak taken
        send_branch(a, a);          // weak taken -> strong taken
        send_branch(a, '0);
        send_branch(a, '0);         // weak taken -> strong not-taken
        send_branch(a, '0);         // hold at strong not-taken
        send_branch(a, a);          // strong not-taken -> weak not-taken
        send_branch(a, '0);         // weak not-taken -> strong not-taken
        send_branch(a, a);
        send_branch(a, a);          // weak not-taken -> strong taken
        send_branch(b, b);          // conflict evicts a
        send_branch(c, c);

        // One-bit mode on histories left at 3 by the two-bit mode.
        set_mode(MODE_ONE_BIT);
        send_branch(b, '0);
        send_branch(c, c);

        // Spare mode value and mode 0 ignore the table.
        set_mode(MODE_SPARE);
        send_branch(a, a);
        send_branch(a, a ^ 32'h1);
        set_mode(MODE_NOT_TAKEN);
        send_branch(32'h1234_5678, 32'h1234_5678);
        send_branch(32'hFFFF_FFFF, 32'hFFFF_FFFE);

        // Random phases: none, sender idle, receiver stall, both.
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_mode(mode_for_phase(p));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            refill_pool();
            repeat (PHASE_BEATS) send_random_branch();
        end

        drain_branches();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
